// ----- sv/gpe_pkg.sv -----
// gpe_pkg: shared types, step addresses and microcode rom of the goldbach pair enumerator
`timescale 1ns / 1ps
package gpe_pkg;

	typedef logic [3:0] upc_t;

	// datapath actions, one per control word
	typedef enum logic [3:0] {
		A_NOP,
		A_LOAD,
		A_SETV_P,
		A_SETV_Q,
		A_DIV_GO,
		A_D_INC,
		A_P_INC,
		A_PAIR,
		A_TRUNC,
		A_FINISH
	} act_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NO_START,
		C_P_GT_HALF,
		C_SQ_GT_V,
		C_DIV_BUSY,
		C_REM_ZERO,
		C_WHICH_HI,
		C_CNT_FULL
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	// status flags from the datapath to the sequencer
	typedef struct packed {
		logic start;
		logic p_gt_half;
		logic sq_gt_v;
		logic div_busy;
		logic rem_zero;
		logic which_hi;
		logic cnt_full;
	} stat_t;

	localparam upc_t ST_IDLE     = 4'd0;
	localparam upc_t ST_CHKP     = 4'd1;
	localparam upc_t ST_SETV_P   = 4'd2;
	localparam upc_t ST_TLOOP    = 4'd3;
	localparam upc_t ST_DIVGO    = 4'd4;
	localparam upc_t ST_DIVWAIT  = 4'd5;
	localparam upc_t ST_REMCHK   = 4'd6;
	localparam upc_t ST_DINC     = 4'd7;
	localparam upc_t ST_VPRIME   = 4'd8;
	localparam upc_t ST_SETV_Q   = 4'd9;
	localparam upc_t ST_NOTPRIME = 4'd10;
	localparam upc_t ST_PAIRCHK  = 4'd11;
	localparam upc_t ST_PAIR     = 4'd12;
	localparam upc_t ST_TRUNC    = 4'd13;
	localparam upc_t ST_FINISH   = 4'd14;

	function automatic ctrl_t ucode_rom(input upc_t a);
		ctrl_t w;
		unique case (a)
			ST_IDLE:     w = '{A_LOAD,   C_NO_START,  ST_IDLE};
			ST_CHKP:     w = '{A_NOP,    C_P_GT_HALF, ST_FINISH};
			ST_SETV_P:   w = '{A_SETV_P, C_NONE,      ST_IDLE};
			ST_TLOOP:    w = '{A_NOP,    C_SQ_GT_V,   ST_VPRIME};
			ST_DIVGO:    w = '{A_DIV_GO, C_NONE,      ST_IDLE};
			ST_DIVWAIT:  w = '{A_NOP,    C_DIV_BUSY,  ST_DIVWAIT};
			ST_REMCHK:   w = '{A_NOP,    C_REM_ZERO,  ST_NOTPRIME};
			ST_DINC:     w = '{A_D_INC,  C_ALWAYS,    ST_TLOOP};
			ST_VPRIME:   w = '{A_NOP,    C_WHICH_HI,  ST_PAIRCHK};
			ST_SETV_Q:   w = '{A_SETV_Q, C_ALWAYS,    ST_TLOOP};
			ST_NOTPRIME: w = '{A_P_INC,  C_ALWAYS,    ST_CHKP};
			ST_PAIRCHK:  w = '{A_NOP,    C_CNT_FULL,  ST_TRUNC};
			ST_PAIR:     w = '{A_PAIR,   C_ALWAYS,    ST_CHKP};
			ST_TRUNC:    w = '{A_TRUNC,  C_ALWAYS,    ST_IDLE};
			ST_FINISH:   w = '{A_FINISH, C_ALWAYS,    ST_IDLE};
			default:     w = '{A_NOP,    C_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- sv/gpe_seq.sv -----
// gpe_seq: microprogram counter, control rom lookup and conditional jumps
`timescale 1ns / 1ps
module gpe_seq
	import gpe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl,
	output logic  busy
);

	upc_t upc_q;
	upc_t upc_d;
	logic jump;

	assign ctrl = ucode_rom(upc_q);
	assign busy = (upc_q != ST_IDLE);

	always_comb begin
		unique case (ctrl.cond)
			C_NONE:      jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_NO_START:  jump = !stat.start;
			C_P_GT_HALF: jump = stat.p_gt_half;
			C_SQ_GT_V:   jump = stat.sq_gt_v;
			C_DIV_BUSY:  jump = stat.div_busy;
			C_REM_ZERO:  jump = stat.rem_zero;
			C_WHICH_HI:  jump = stat.which_hi;
			C_CNT_FULL:  jump = stat.cnt_full;
			default:     jump = 1'b1;
		endcase
		upc_d = jump ? ctrl.target : upc_q + upc_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ----- sv/gpe_div.sv -----
// gpe_div: bit-serial restoring divider that yields the remainder
`timescale 1ns / 1ps
module gpe_div #(
	parameter int W = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rem_sh;

	assign busy   = (cnt_q != '0);
	assign rem    = rem_q;
	assign rem_sh = {rem_q, dvd_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (go) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, divisor}) begin
				rem_q <= W'(rem_sh - {1'b0, divisor});
			end else begin
				rem_q <= rem_sh[W-1:0];
			end
		end
	end

endmodule

// ----- sv/gpe_dp.sv -----
// gpe_dp: candidate, trial divisor and pending pair registers with the result register
`timescale 1ns / 1ps
module gpe_dp
	import gpe_pkg::*;
#(
	parameter int VALUE_BITS = 10,
	parameter int MAX_PAIRS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] target_value,
	output stat_t                 stat,
	output logic                  result_valid,
	output logic [VALUE_BITS-2:0] smaller_prime,
	output logic [VALUE_BITS-1:0] larger_prime,
	output logic                  pair_found,
	output logic                  last_of_run,
	output logic                  truncated
);

	localparam int VB = VALUE_BITS;
	localparam int CW = $clog2(MAX_PAIRS + 1);

	logic [VB-1:0]   n_q, p_q, v_q, d_q;
	logic [2*VB-1:0] sq_q;
	logic            which_q;
	logic [CW-1:0]   cnt_q;
	logic            pend_v_q;
	logic [VB-2:0]   pend_lo_q;
	logic [VB-1:0]   pend_hi_q;
	logic            div_go;
	logic            div_busy;
	logic [VB-1:0]   div_rem;

	logic            res_valid_q;
	logic [VB-2:0]   res_lo_q;
	logic [VB-1:0]   res_hi_q;
	logic            res_found_q, res_last_q, res_trunc_q;

	assign div_go = (ctrl.act == A_DIV_GO);

	gpe_div #(.W(VB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (v_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	always_comb begin
		stat.start     = start;
		stat.p_gt_half = (p_q > (n_q >> 1));
		stat.sq_gt_v   = (sq_q > {{VB{1'b0}}, v_q});
		stat.div_busy  = div_busy;
		stat.rem_zero  = (div_rem == '0);
		stat.which_hi  = which_q;
		stat.cnt_full  = (cnt_q == CW'(MAX_PAIRS));
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			which_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (ctrl.act)
				A_LOAD: begin
					cnt_q    <= '0;
					pend_v_q <= 1'b0;
					which_q  <= 1'b0;
				end
				A_SETV_P: which_q <= 1'b0;
				A_SETV_Q: which_q <= 1'b1;
				A_PAIR: begin
					res_valid_q <= pend_v_q;
					pend_v_q    <= 1'b1;
					cnt_q       <= cnt_q + CW'(1);
				end
				A_TRUNC:  res_valid_q <= 1'b1;
				A_FINISH: res_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			A_LOAD: begin
				n_q <= target_value;
				p_q <= VB'(2);
			end
			A_SETV_P: begin
				v_q  <= p_q;
				d_q  <= VB'(2);
				sq_q <= (2*VB)'(4);
			end
			A_SETV_Q: begin
				v_q  <= n_q - p_q;
				d_q  <= VB'(2);
				sq_q <= (2*VB)'(4);
			end
			A_D_INC: begin
				d_q  <= d_q + VB'(1);
				sq_q <= sq_q + {{(VB-1){1'b0}}, d_q, 1'b1};
			end
			A_P_INC: p_q <= p_q + VB'(1);
			A_PAIR: begin
				res_lo_q    <= pend_lo_q;
				res_hi_q    <= pend_hi_q;
				res_found_q <= 1'b1;
				res_last_q  <= 1'b0;
				res_trunc_q <= 1'b0;
				pend_lo_q   <= p_q[VB-2:0];
				pend_hi_q   <= v_q;
				p_q         <= p_q + VB'(1);
			end
			A_TRUNC: begin
				res_lo_q    <= pend_lo_q;
				res_hi_q    <= pend_hi_q;
				res_found_q <= 1'b1;
				res_last_q  <= 1'b1;
				res_trunc_q <= 1'b1;
			end
			A_FINISH: begin
				res_lo_q    <= pend_v_q ? pend_lo_q : '0;
				res_hi_q    <= pend_v_q ? pend_hi_q : '0;
				res_found_q <= pend_v_q;
				res_last_q  <= 1'b1;
				res_trunc_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign result_valid  = res_valid_q;
	assign smaller_prime = res_lo_q;
	assign larger_prime  = res_hi_q;
	assign pair_found    = res_found_q;
	assign last_of_run   = res_last_q;
	assign truncated     = res_trunc_q;

endmodule

// ----- sv/goldbach_pair_enumerator.sv -----
// goldbach_pair_enumerator: top level, microcoded search for prime pairs summing to n
//
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// input     | start & !busy             | target_value
// result    | result_valid (one cycle)  | smaller_prime, larger_prime, pair_found,
//           |                           | last_of_run, truncated
//
// one transaction in, then one or more result transactions in ascending order of p;
// the final one carries last_of_run. every candidate is tested by trial division on
// one shared bit-serial divider.
// arst_n clears the step counter, pending pair and strobe; payload registers are not reset.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
`timescale 1ns / 1ps
module goldbach_pair_enumerator
	import gpe_pkg::*;
#(
	parameter int VALUE_BITS = 10,
	parameter int MAX_PAIRS  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] target_value,
	output logic                  result_valid,
	output logic [VALUE_BITS-2:0] smaller_prime,
	output logic [VALUE_BITS-1:0] larger_prime,
	output logic                  pair_found,
	output logic                  last_of_run,
	output logic                  truncated
);

	// control word from the rom, status flags back from the datapath
	ctrl_t ctrl;
	stat_t stat;

	// sequencer: step counter walks the microprogram, idle step loads n on start
	gpe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// datapath: a pair is held back until the next one is found, so that the
	// final result of a run can be marked as last (and truncated when the limit hits)
	gpe_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_PAIRS  (MAX_PAIRS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.start         (start),
		.target_value  (target_value),
		.stat          (stat),
		.result_valid  (result_valid),
		.smaller_prime (smaller_prime),
		.larger_prime  (larger_prime),
		.pair_found    (pair_found),
		.last_of_run   (last_of_run),
		.truncated     (truncated)
	);

	// the first step after accepting a transaction never emits
	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result right after input accept");

	// a final result leaves the block idle, any other result leaves it searching
	a_last_means_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |-> !busy)
		else $error("final result while still busy");

	a_mid_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_run) |-> busy)
		else $error("intermediate result while idle");

	// no-pair result stands alone and is never truncated; truncated only on the last
	a_nopair_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (!pair_found || truncated)) |-> last_of_run)
		else $error("no-pair or truncated result not marked last");

endmodule
